// ===== src/hamt_pkg.sv =====
// ----------------------------------------------------------------------------
// hamt_pkg
// Shared types, constants and fixed-point helpers for the Hessian map block.
// ----------------------------------------------------------------------------
package hamt_pkg;

	localparam int MAX_ROWS   = 32;
	localparam int MAX_POINTS = 32;
	localparam int FRAC_BITS  = 16;

	localparam int MAP_N   = 3;
	localparam int STORE_D = MAX_ROWS * MAX_POINTS;
	localparam int TR_D    = MAX_ROWS * MAX_ROWS;
	localparam int ADDR_W  = $clog2(STORE_D);
	localparam int TADDR_W = $clog2(TR_D);
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int PT_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W   = 6;
	localparam int DIVD_W  = 32 + FRAC_BITS;
	localparam int ACC_W   = 72;

	localparam logic signed [ACC_W-1:0] HALF_Q = 72'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Q_MAX  = 72'sd2147483647;
	localparam logic signed [ACC_W-1:0] Q_MIN  = -72'sd2147483648;

	typedef enum logic [2:0] {
		OP_LOAD_MAP = 3'd0,
		OP_LOAD_TR  = 3'd1,
		OP_LOAD_REF = 3'd2,
		OP_COMPUTE  = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_RANGE    = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ENG_IDLE,
		ENG_READ,
		ENG_ADJ,
		ENG_DET,
		ENG_DIV,
		ENG_MIX_RD,
		ENG_MIX,
		ENG_TR_RD,
		ENG_TR,
		ENG_TR_WR,
		ENG_CLEAR
	} eng_state_t;

	typedef struct packed {
		logic [2:0]          operation;
		logic [4:0]          row_index;
		logic [4:0]          column_index;
		logic signed [31:0]  value_xx;
		logic signed [31:0]  value_xy;
		logic signed [31:0]  value_yy;
	} item_in_t;

	typedef struct packed {
		logic signed [31:0]  out_xx;
		logic signed [31:0]  out_xy;
		logic signed [31:0]  out_yy;
		logic [1:0]          status;
	} item_out_t;

	typedef struct packed {
		logic      valid;
		item_in_t  item;
	} eng_cmd_t;

	typedef struct packed {
		logic       valid;
		item_out_t  item;
	} eng_rsp_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	function automatic logic signed [ACC_W-1:0] sx64(input logic signed [63:0] v);
		return {{(ACC_W-64){v[63]}}, v};
	endfunction

	// round to nearest, ties up, then floor shift
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
		return (v + HALF_Q) >>> FRAC_BITS;
	endfunction

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t s;
		if (v > Q_MAX) begin
			s.ovf = 1'b1;
			s.val = 32'sh7fffffff;
		end else if (v < Q_MIN) begin
			s.ovf = 1'b1;
			s.val = 32'sh80000000;
		end else begin
			s.ovf = 1'b0;
			s.val = v[31:0];
		end
		return s;
	endfunction

	function automatic logic [3:0] idx3(input logic [1:0] i, input logic [1:0] j);
		return 4'(i) * 4'(MAP_N) + 4'(j);
	endfunction

	function automatic logic [1:0] mod3(input logic [2:0] x);
		return (x >= 3'(MAP_N)) ? 2'(x - 3'(MAP_N)) : x[1:0];
	endfunction

	function automatic logic [3:0] map_idx(input logic [2:0] r, input logic [2:0] c);
		return idx3(mod3(r), mod3(c));
	endfunction

endpackage

// ===== src/hamt_ram.sv =====
// ----------------------------------------------------------------------------
// hamt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hamt_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/hamt_div.sv =====
// ----------------------------------------------------------------------------
// hamt_div
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module hamt_div import hamt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIVD_W-1:0] dividend,
	input  logic signed [31:0]       divisor,
	output logic                     done,
	output logic signed [DIVD_W:0]   quotient
);

	localparam int DC_W = $clog2(DIVD_W + 1);

	logic              busy_q, done_q, neg_q;
	logic [DC_W-1:0]   cnt_q;
	logic [31:0]       rem_q, dvs_q;
	logic [DIVD_W-1:0] quo_q;
	logic [32:0]       sh;
	logic              ge;

	assign sh = {rem_q, quo_q[DIVD_W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DC_W'(1);
				if (cnt_q == DC_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
			dvs_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
			neg_q <= dividend[DIVD_W-1] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(sh - {1'b0, dvs_q}) : sh[31:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== src/hamt_engine.sv =====
// ----------------------------------------------------------------------------
// hamt_engine
// Store owner and compute sequencer: loads, reads, adjugate, determinant,
// inverse, mixing pass and transform product over one shared multiplier.
// ----------------------------------------------------------------------------
module hamt_engine import hamt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  eng_cmd_t         cmd,
	input  logic [CNT_W-1:0] rows,
	input  logic [CNT_W-1:0] pts,
	output logic             ready,
	output eng_rsp_t         rsp
);

	localparam logic [1:0] L3 = 2'(MAP_N - 1);

	eng_state_t state_q, state_d;

	logic              ph_q, sub_q, sat_q, rsp_vld_q;
	logic [1:0]        ci_q, cj_q, cstat_q;
	logic [ROW_W-1:0]  k_q, r_q;
	logic [PT_W-1:0]   p_q;
	logic [ADDR_W-1:0] clr_q;
	item_out_t         rsp_item_q;

	logic signed [31:0]      map_q [MAP_N*MAP_N];
	logic signed [31:0]      adj_q [MAP_N*MAP_N];
	logic signed [31:0]      inv_q [MAP_N*MAP_N];
	logic signed [31:0]      det_q;
	logic signed [31:0]      mixv_q [2];
	logic signed [63:0]      prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] s_q [MAP_N];

	logic [2:0] op;
	logic [4:0] row, col;
	logic       map_ok, tr_ok, st_ok;
	logic [CNT_W-1:0] rows_m1, pts_m1;
	logic       k_last, p_last, r_last;
	logic [1:0] idle_st;

	logic signed [31:0]      opa, opb, ref_sel, mix_sel;
	logic signed [ACC_W-1:0] term, acc_sum;
	sat_t                    adj_s, sum_s, inv_s;
	sat_t                    res_s [MAP_N];

	logic               tr_we, tr_re, ref_we, ref_re, mix_we, mix_re, res_we, res_re;
	logic [TADDR_W-1:0] tr_waddr, tr_raddr;
	logic [ADDR_W-1:0]  ref_waddr, ref_raddr, mix_addr, mix_raddr, res_waddr, res_raddr;
	logic [95:0]        ref_wdata, mix_wdata, res_wdata;
	logic [31:0]        tr_rdata;
	logic [95:0]        ref_rdata, mix_rdata, res_rdata;

	logic                     div_start, div_done;
	logic signed [DIVD_W-1:0] div_dvd;
	logic signed [DIVD_W:0]   div_q;

	assign op  = cmd.item.operation;
	assign row = cmd.item.row_index;
	assign col = cmd.item.column_index;

	assign map_ok = (row < 5'(MAP_N)) && (col < 5'(MAP_N));
	assign tr_ok  = (int'(row) < MAX_ROWS) && (int'(col) < MAX_ROWS);
	assign st_ok  = (int'(row) < MAX_ROWS) && (int'(col) < MAX_POINTS);

	assign rows_m1 = rows - CNT_W'(1);
	assign pts_m1  = pts - CNT_W'(1);
	assign k_last  = CNT_W'(k_q) == rows_m1;
	assign r_last  = CNT_W'(r_q) == rows_m1;
	assign p_last  = CNT_W'(p_q) == pts_m1;

	always_comb begin
		case (op)
			OP_LOAD_MAP: idle_st = map_ok ? ST_OK : ST_RANGE;
			OP_LOAD_TR:  idle_st = tr_ok ? ST_OK : ST_RANGE;
			OP_LOAD_REF: idle_st = st_ok ? ST_OK : ST_RANGE;
			default:     idle_st = ST_RANGE;
		endcase
	end

	// datapath arithmetic
	always_comb begin
		case (ci_q)
			2'd0:    ref_sel = ref_rdata[95:64];
			2'd1:    ref_sel = ref_rdata[63:32];
			default: ref_sel = ref_rdata[31:0];
		endcase
		case (cj_q)
			2'd0:    mix_sel = mix_rdata[95:64];
			2'd1:    mix_sel = mix_rdata[63:32];
			default: mix_sel = mix_rdata[31:0];
		endcase
	end

	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			ENG_ADJ: begin
				if (sub_q) begin
					opa = map_q[map_idx({1'b0, cj_q} + 3'd1, {1'b0, ci_q} + 3'd2)];
					opb = map_q[map_idx({1'b0, cj_q} + 3'd2, {1'b0, ci_q} + 3'd1)];
				end else begin
					opa = map_q[map_idx({1'b0, cj_q} + 3'd1, {1'b0, ci_q} + 3'd1)];
					opb = map_q[map_idx({1'b0, cj_q} + 3'd2, {1'b0, ci_q} + 3'd2)];
				end
			end
			ENG_DET: begin
				opa = map_q[idx3(2'd0, cj_q)];
				opb = adj_q[idx3(cj_q, 2'd0)];
			end
			ENG_MIX: begin
				opa = ref_sel;
				opb = inv_q[idx3(ci_q, cj_q)];
			end
			ENG_TR: begin
				opa = tr_rdata;
				opb = mix_sel;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign term    = rnd(sx64(prod_q));
	assign acc_sum = ((state_q == ENG_MIX) && (ci_q == 2'd0)) ? term : acc_q + term;
	assign adj_s   = sat32(rnd(acc_q - sx64(prod_q)));
	assign sum_s   = sat32(acc_sum);
	assign inv_s   = sat32({{(ACC_W-DIVD_W-1){div_q[DIVD_W]}}, div_q});
	assign div_dvd = {adj_q[idx3(ci_q, cj_q)], {FRAC_BITS{1'b0}}};

	always_comb begin
		for (int i = 0; i < MAP_N; i++) begin
			res_s[i] = sat32(s_q[i]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd.valid) begin
					if (op == OP_COMPUTE) begin
						state_d = ENG_ADJ;
					end else if ((op == OP_READ) && st_ok) begin
						state_d = ENG_READ;
					end
				end
			end
			ENG_READ: state_d = ENG_IDLE;
			ENG_ADJ: begin
				if (ph_q && sub_q && (ci_q == L3) && (cj_q == L3)) state_d = ENG_DET;
			end
			ENG_DET: begin
				if (ph_q && (cj_q == L3)) begin
					state_d = (sum_s.val == '0) ? ENG_CLEAR : ENG_DIV;
				end
			end
			ENG_DIV: begin
				if (ph_q && div_done && (ci_q == L3) && (cj_q == L3)) state_d = ENG_MIX_RD;
			end
			ENG_MIX_RD: state_d = ENG_MIX;
			ENG_MIX: begin
				if (ph_q && (ci_q == L3) && (cj_q == L3)) begin
					state_d = (k_last && p_last) ? ENG_TR_RD : ENG_MIX_RD;
				end
			end
			ENG_TR_RD: state_d = ENG_TR;
			ENG_TR: begin
				if (ph_q && (cj_q == L3)) state_d = k_last ? ENG_TR_WR : ENG_TR_RD;
			end
			ENG_TR_WR: state_d = (p_last && r_last) ? ENG_IDLE : ENG_TR_RD;
			ENG_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_D - 1)) state_d = ENG_IDLE;
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		tr_we     = (state_q == ENG_IDLE) && cmd.valid && (op == OP_LOAD_TR) && tr_ok;
		tr_waddr  = TADDR_W'(int'(row) * MAX_ROWS + int'(col));
		tr_re     = state_q == ENG_TR_RD;
		tr_raddr  = TADDR_W'(int'(r_q) * MAX_ROWS + int'(k_q));

		ref_we    = (state_q == ENG_IDLE) && cmd.valid && (op == OP_LOAD_REF) && st_ok;
		ref_waddr = ADDR_W'(int'(row) * MAX_POINTS + int'(col));
		ref_wdata = {cmd.item.value_xx, cmd.item.value_xy, cmd.item.value_yy};
		ref_re    = state_q == ENG_MIX_RD;
		ref_raddr = ADDR_W'(int'(k_q) * MAX_POINTS + int'(p_q));

		mix_addr  = ADDR_W'(int'(k_q) * MAX_POINTS + int'(p_q));
		mix_we    = (state_q == ENG_MIX) && ph_q && (ci_q == L3) && (cj_q == L3);
		mix_wdata = {mixv_q[0], mixv_q[1], sum_s.val};
		mix_re    = state_q == ENG_TR_RD;
		mix_raddr = mix_addr;

		res_we    = (state_q == ENG_TR_WR) || (state_q == ENG_CLEAR);
		res_waddr = (state_q == ENG_CLEAR) ? clr_q
		                                   : ADDR_W'(int'(r_q) * MAX_POINTS + int'(p_q));
		res_wdata = (state_q == ENG_CLEAR) ? '0 : {res_s[0].val, res_s[1].val, res_s[2].val};
		res_re    = (state_q == ENG_IDLE) && cmd.valid && (op == OP_READ) && st_ok;
		res_raddr = ref_waddr;

		div_start = (state_q == ENG_DIV) && !ph_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ENG_IDLE;
			ph_q      <= 1'b0;
			sub_q     <= 1'b0;
			ci_q      <= '0;
			cj_q      <= '0;
			k_q       <= '0;
			p_q       <= '0;
			r_q       <= '0;
			clr_q     <= '0;
			sat_q     <= 1'b0;
			cstat_q   <= ST_OK;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rsp_vld_q <= 1'b0;
			unique case (state_q)
				ENG_IDLE: begin
					if (cmd.valid) begin
						if (op == OP_COMPUTE) begin
							ph_q  <= 1'b0;
							sub_q <= 1'b0;
							ci_q  <= '0;
							cj_q  <= '0;
							k_q   <= '0;
							p_q   <= '0;
							r_q   <= '0;
							sat_q <= 1'b0;
						end else if (!((op == OP_READ) && st_ok)) begin
							rsp_vld_q <= 1'b1;
						end
					end
				end
				ENG_READ: rsp_vld_q <= 1'b1;
				ENG_ADJ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sub_q <= !sub_q;
						if (sub_q) begin
							sat_q <= sat_q | adj_s.ovf;
							if (cj_q == L3) begin
								cj_q <= '0;
								ci_q <= (ci_q == L3) ? 2'd0 : ci_q + 2'd1;
							end else begin
								cj_q <= cj_q + 2'd1;
							end
						end
					end
				end
				ENG_DET: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cj_q == L3) begin
							cj_q  <= '0;
							sat_q <= sat_q | sum_s.ovf;
							clr_q <= '0;
						end else begin
							cj_q <= cj_q + 2'd1;
						end
					end
				end
				ENG_DIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (div_done) begin
						ph_q  <= 1'b0;
						sat_q <= sat_q | inv_s.ovf;
						if (cj_q == L3) begin
							cj_q <= '0;
							ci_q <= (ci_q == L3) ? 2'd0 : ci_q + 2'd1;
						end else begin
							cj_q <= cj_q + 2'd1;
						end
					end
				end
				ENG_MIX_RD: begin
					ph_q <= 1'b0;
					ci_q <= '0;
					cj_q <= '0;
				end
				ENG_MIX: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (ci_q == L3) begin
							ci_q  <= '0;
							sat_q <= sat_q | sum_s.ovf;
							if (cj_q == L3) begin
								cj_q <= '0;
								if (p_last) begin
									p_q <= '0;
									k_q <= k_last ? '0 : k_q + ROW_W'(1);
								end else begin
									p_q <= p_q + PT_W'(1);
								end
							end else begin
								cj_q <= cj_q + 2'd1;
							end
						end else begin
							ci_q <= ci_q + 2'd1;
						end
					end
				end
				ENG_TR_RD: begin
					ph_q <= 1'b0;
					cj_q <= '0;
				end
				ENG_TR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cj_q == L3) begin
							cj_q <= '0;
							if (!k_last) k_q <= k_q + ROW_W'(1);
						end else begin
							cj_q <= cj_q + 2'd1;
						end
					end
				end
				ENG_TR_WR: begin
					k_q   <= '0;
					sat_q <= sat_q | res_s[0].ovf | res_s[1].ovf | res_s[2].ovf;
					if (p_last) begin
						p_q <= '0;
						r_q <= r_last ? '0 : r_q + ROW_W'(1);
					end else begin
						p_q <= p_q + PT_W'(1);
					end
					if (p_last && r_last) begin
						cstat_q   <= (sat_q | res_s[0].ovf | res_s[1].ovf | res_s[2].ovf)
						             ? ST_SAT : ST_OK;
						rsp_vld_q <= 1'b1;
					end
				end
				ENG_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_D - 1)) begin
						cstat_q   <= ST_SINGULAR;
						rsp_vld_q <= 1'b1;
					end
				end
				default: ph_q <= 1'b0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		case (state_q)
			ENG_IDLE: begin
				if (cmd.valid && (op == OP_LOAD_MAP) && map_ok) begin
					map_q[idx3(row[1:0], col[1:0])] <= cmd.item.value_xx;
				end
				acc_q             <= '0;
				rsp_item_q.out_xx <= '0;
				rsp_item_q.out_xy <= '0;
				rsp_item_q.out_yy <= '0;
				rsp_item_q.status <= idle_st;
			end
			ENG_READ: begin
				rsp_item_q.out_xx <= res_rdata[95:64];
				rsp_item_q.out_xy <= res_rdata[63:32];
				rsp_item_q.out_yy <= res_rdata[31:0];
				rsp_item_q.status <= cstat_q;
			end
			ENG_ADJ: begin
				if (ph_q) begin
					if (sub_q) begin
						adj_q[idx3(ci_q, cj_q)] <= adj_s.val;
						acc_q                   <= '0;
					end else begin
						acc_q <= sx64(prod_q);
					end
				end
			end
			ENG_DET: begin
				if (ph_q) begin
					acc_q <= acc_sum;
					if (cj_q == L3) det_q <= sum_s.val;
				end
			end
			ENG_DIV: begin
				if (ph_q && div_done) inv_q[idx3(ci_q, cj_q)] <= inv_s.val;
			end
			ENG_MIX: begin
				for (int i = 0; i < MAP_N; i++) s_q[i] <= '0;
				if (ph_q) begin
					acc_q <= acc_sum;
					if (ci_q == L3) begin
						if (cj_q == 2'd0) mixv_q[0] <= sum_s.val;
						if (cj_q == 2'd1) mixv_q[1] <= sum_s.val;
					end
				end
			end
			ENG_TR: begin
				if (ph_q) s_q[cj_q] <= s_q[cj_q] + term;
			end
			ENG_TR_WR: begin
				for (int i = 0; i < MAP_N; i++) s_q[i] <= '0;
				rsp_item_q.out_xx <= '0;
				rsp_item_q.out_xy <= '0;
				rsp_item_q.out_yy <= '0;
				rsp_item_q.status <= (sat_q | res_s[0].ovf | res_s[1].ovf | res_s[2].ovf)
				                     ? ST_SAT : ST_OK;
			end
			ENG_CLEAR: begin
				rsp_item_q.out_xx <= '0;
				rsp_item_q.out_xy <= '0;
				rsp_item_q.out_yy <= '0;
				rsp_item_q.status <= ST_SINGULAR;
			end
			default: acc_q <= acc_q;
		endcase
	end

	hamt_ram #(.W(32), .D(TR_D)) u_tr_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_waddr),
		.wdata (cmd.item.value_xx),
		.re    (tr_re),
		.raddr (tr_raddr),
		.rdata (tr_rdata)
	);

	hamt_ram #(.W(96), .D(STORE_D)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (ref_re),
		.raddr (ref_raddr),
		.rdata (ref_rdata)
	);

	hamt_ram #(.W(96), .D(STORE_D)) u_mix_ram (
		.clk   (clk),
		.we    (mix_we),
		.waddr (mix_addr),
		.wdata (mix_wdata),
		.re    (mix_re),
		.raddr (mix_raddr),
		.rdata (mix_rdata)
	);

	hamt_ram #(.W(96), .D(STORE_D)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.re    (res_re),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	hamt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (det_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign ready      = (state_q == ENG_IDLE) && !rsp_vld_q;
	assign rsp.valid  = rsp_vld_q;
	assign rsp.item   = rsp_item_q;

endmodule

// ===== src/hessian_affine_map_and_basis_transform.sv =====
// ----------------------------------------------------------------------------
// hessian_affine_map_and_basis_transform
// Q16.16 Hessian mapping: 3x3 map inverse, triple mixing and transform
// product over RAM-held stores, with handshake front end and APB registers.
// ----------------------------------------------------------------------------
// channel  | signals                      | beat taken when
// ---------+------------------------------+--------------------------
// command  | cmd_valid, cmd_stall, cmd    | cmd_valid & !cmd_stall
// result   | rsp_valid, rsp_stall, rsp    | rsp_valid & !rsp_stall
// config   | psel, penable, pwrite, paddr | psel & penable & pwrite
//
// A load is answered through the engine response stage and the output
// register; a read first passes the result RAM read port. Compute runs
// on one shared multiplier and a bit-serial divider; a singular map
// sweeps all result entries.
// One command at a time; a stalled result beat holds off the next command.
// ----------------------------------------------------------------------------
module hessian_affine_map_and_basis_transform import hamt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  item_in_t    cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output item_out_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CNT_W-1:0] rows_q, pts_q, rows, pts;
	logic             eng_ready, out_vld_q;
	item_out_t        out_item_q;
	eng_cmd_t         eng_cmd;
	eng_rsp_t         eng_rsp;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CNT_W'(21);
			pts_q  <= CNT_W'(32);
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) pts_q <= pwdata[CNT_W-1:0];
			else          rows_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = paddr[2] ? 32'(pts_q) : 32'(rows_q);

	assign rows = (rows_q == '0) ? CNT_W'(1)
	            : (int'(rows_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : rows_q;
	assign pts  = (pts_q == '0) ? CNT_W'(1)
	            : (int'(pts_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : pts_q;

	assign cmd_stall     = !eng_ready || (out_vld_q && rsp_stall);
	assign eng_cmd.valid = cmd_valid && !cmd_stall;
	assign eng_cmd.item  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (eng_rsp.valid) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_rsp.valid) out_item_q <= eng_rsp.item;
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_item_q;

	hamt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (eng_cmd),
		.rows   (rows),
		.pts    (pts),
		.ready  (eng_ready),
		.rsp    (eng_rsp)
	);

endmodule

// ===== verif/hamt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamt_checker
// Watches the command, result and register channels of the Hessian map block,
// keeps its own Q16.16 copy of the stores and compares every result beat
// field by field with the oldest predicted triple and status.
// ----------------------------------------------------------------------------
module hamt_checker import hamt_pkg::*; #(
	parameter logic [2:0] ROWS_ADDR   = 3'd0,
	parameter logic [2:0] POINTS_ADDR = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  item_in_t    cmd,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  item_out_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	typedef logic signed [79:0] wide_t;
	typedef logic signed [31:0] q_t;

	q_t        map_q [9];
	q_t        xform [TR_D];
	q_t        ref_q [3][STORE_D];
	q_t        res_q [3][STORE_D];
	q_t        mixed [3][STORE_D];
	status_t   calc_status;
	logic [5:0] rows_reg, points_reg;
	item_out_t triple_q[$];

	function automatic wide_t qround(input wide_t v);
		return (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic q_t clip(input wide_t v, inout bit s);
		if (v > wide_t'(32'sh7fffffff)) begin
			s = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < wide_t'(32'sh80000000)) begin
			s = 1'b1;
			return 32'sh80000000;
		end
		return q_t'(v);
	endfunction

	function automatic wide_t qmul(input q_t a, input q_t b);
		wide_t wa, wb;
		wa = wide_t'(a);
		wb = wide_t'(b);
		return qround(wa * wb);
	endfunction

	function automatic wide_t mv(input int r, input int c);
		return wide_t'(map_q[(r % 3) * 3 + (c % 3)]);
	endfunction

	function automatic int span(input logic [5:0] v, input int top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	function automatic void run_hessian();
		q_t    adj [3][3];
		q_t    inv [3][3];
		bit    s;
		int    nr, np, a, b;
		wide_t acc, s0, s1, s2;
		q_t    det, c;
		s = 1'b0;
		nr = span(rows_reg, MAX_ROWS);
		np = span(points_reg, MAX_POINTS);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				adj[i][j] = clip(qround(mv(j + 1, i + 1) * mv(j + 2, i + 2)
					- mv(j + 1, i + 2) * mv(j + 2, i + 1)), s);
		acc = 0;
		for (int j = 0; j < 3; j++)
			acc += qmul(map_q[j], adj[j][0]);
		det = clip(acc, s);
		if (det == 0) begin
			for (int k = 0; k < STORE_D; k++)
				for (int f = 0; f < 3; f++)
					res_q[f][k] = '0;
			calc_status = ST_SINGULAR;
			return;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				inv[i][j] = clip((wide_t'(adj[i][j]) <<< FRAC_BITS) / wide_t'(det), s);
		for (int k = 0; k < nr; k++)
			for (int p = 0; p < np; p++) begin
				a = k * MAX_POINTS + p;
				for (int j = 0; j < 3; j++)
					mixed[j][a] = clip(qmul(ref_q[0][a], inv[0][j])
						+ qmul(ref_q[1][a], inv[1][j])
						+ qmul(ref_q[2][a], inv[2][j]), s);
			end
		for (int r = 0; r < nr; r++)
			for (int p = 0; p < np; p++) begin
				s0 = 0;
				s1 = 0;
				s2 = 0;
				a = r * MAX_POINTS + p;
				for (int k = 0; k < nr; k++) begin
					c = xform[r * MAX_ROWS + k];
					b = k * MAX_POINTS + p;
					s0 += qmul(c, mixed[0][b]);
					s1 += qmul(c, mixed[1][b]);
					s2 += qmul(c, mixed[2][b]);
				end
				res_q[0][a] = clip(s0, s);
				res_q[1][a] = clip(s1, s);
				res_q[2][a] = clip(s2, s);
			end
		calc_status = s ? ST_SAT : ST_OK;
	endfunction

	function automatic item_out_t predict_beat(input item_in_t it);
		item_out_t o;
		int a;
		o = '0;
		a = it.row_index * MAX_POINTS + it.column_index;
		case (it.operation)
			OP_LOAD_MAP: begin
				if (it.row_index < 3 && it.column_index < 3)
					map_q[it.row_index * 3 + it.column_index] = it.value_xx;
				else
					o.status = ST_RANGE;
			end
			OP_LOAD_TR: begin
				xform[it.row_index * MAX_ROWS + it.column_index] = it.value_xx;
			end
			OP_LOAD_REF: begin
				ref_q[0][a] = it.value_xx;
				ref_q[1][a] = it.value_xy;
				ref_q[2][a] = it.value_yy;
			end
			OP_COMPUTE: begin
				run_hessian();
				o.status = calc_status;
			end
			OP_READ: begin
				o.out_xx = res_q[0][a];
				o.out_xy = res_q[1][a];
				o.out_yy = res_q[2][a];
				o.status = calc_status;
			end
			default: o.status = ST_RANGE;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) map_q[k] = '0;
			for (int k = 0; k < TR_D; k++) xform[k] = '0;
			for (int f = 0; f < 3; f++)
				for (int k = 0; k < STORE_D; k++) begin
					ref_q[f][k] = '0;
					res_q[f][k] = '0;
					mixed[f][k] = '0;
				end
			calc_status = ST_OK;
			rows_reg    = 6'd21;
			points_reg  = 6'd32;
			triple_q.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ROWS_ADDR)
					rows_reg = pwdata[5:0];
				else if (paddr == POINTS_ADDR)
					points_reg = pwdata[5:0];
			end
			if (rsp_valid && !rsp_stall) begin
				if (triple_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] unexpected result beat %h", $realtime, rsp);
				end else begin
					want = triple_q.pop_front();
					if (rsp.out_xx !== want.out_xx || rsp.out_xy !== want.out_xy
							|| rsp.out_yy !== want.out_yy || rsp.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"[%0t] mismatch: exp xx %h xy %h yy %h st %0d,",
								" got xx %h xy %h yy %h st %0d"},
								$realtime, want.out_xx, want.out_xy, want.out_yy,
								want.status, rsp.out_xx, rsp.out_xy, rsp.out_yy,
								rsp.status);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				triple_q.push_back(predict_beat(cmd));
			pending = triple_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the Hessian map block: directed loads, singular and identity maps,
// register extremes, then random small-size phases with random idling and a
// long result hold-off. The checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import hamt_pkg::*;

	localparam logic [2:0] ROWS_ADDR   = 3'd0;
	localparam logic [2:0] POINTS_ADDR = 3'd4;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int         Q_ONE       = 1 << FRAC_BITS;
	localparam longint     CYCLE_LIMIT = 3000000;

	logic        clk, arst_n;
	logic        cmd_valid, cmd_stall, rsp_valid, rsp_stall;
	item_in_t    cmd;
	item_out_t   rsp;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, pending;

	bit     quiet, start_hold;
	int     hold_left;
	longint cycles;
	int     op_seen [8];
	int     computes_run, phases_run, sent;

	hessian_affine_map_and_basis_transform dut (.*);

	hamt_checker #(.ROWS_ADDR(ROWS_ADDR), .POINTS_ADDR(POINTS_ADDR)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (start_hold) begin
			start_hold = 1'b0;
			hold_left  = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(99) < 6);
		end
	end

	task automatic send(input item_in_t it);
		cmd       <= it;
		cmd_valid <= 1'b1;
		@(negedge clk);
		while (cmd_stall) @(negedge clk);
		@(posedge clk);
		op_seen[it.operation]++;
		sent++;
		if (it.operation == OP_COMPUTE) computes_run++;
		if (!quiet && $urandom_range(99) < 6) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] op, input int r, input int c,
			input logic [31:0] xx, input logic [31:0] xy, input logic [31:0] yy);
		item_in_t it;
		it.operation    = op;
		it.row_index    = r[4:0];
		it.column_index = c[4:0];
		it.value_xx     = xx;
		it.value_xy     = xy;
		it.value_yy     = yy;
		send(it);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] small_q(input int span_q);
		return $urandom_range(0, 2 * span_q) - span_q;
	endfunction

	function automatic logic [31:0] any_q();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4, 5: return $urandom;
			default: return small_q(4 * Q_ONE);
		endcase
	endfunction

	function automatic int span(input int v, input int top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	// map styles: 0 random small, 1 identity, 2 zero row
	task automatic prepare(input int rows_w, input int pts_w, input int style);
		int nr, np;
		logic [31:0] m;
		write_reg(ROWS_ADDR, rows_w);
		write_reg(POINTS_ADDR, pts_w);
		phases_run++;
		nr = span(rows_w & 63, MAX_ROWS);
		np = span(pts_w & 63, MAX_POINTS);
		for (int r = 0; r < nr; r++)
			for (int k = 0; k < nr; k++)
				issue(OP_LOAD_TR, r, k, small_q(2 * Q_ONE), $urandom, $urandom);
		for (int r = 0; r < nr; r++)
			for (int p = 0; p < np; p++)
				issue(OP_LOAD_REF, r, p, any_q(), any_q(), any_q());
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				case (style)
					1: m = (r == c) ? Q_ONE : 0;
					2: m = (r == 1) ? 0 : small_q(3 * Q_ONE);
					default: m = small_q(3 * Q_ONE);
				endcase
				issue(OP_LOAD_MAP, r, c, m, $urandom, $urandom);
			end
	endtask

	task automatic random_item(input int nr, input int np);
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			if ($urandom_range(4) == 0)
				issue(OP_LOAD_MAP, $urandom_range(31), $urandom_range(31), $urandom,
					$urandom, $urandom);
			else
				issue(OP_LOAD_MAP, $urandom_range(2), $urandom_range(2),
					small_q(3 * Q_ONE), $urandom, $urandom);
		end else if (pick < 28)
			issue(OP_LOAD_TR, $urandom_range(31), $urandom_range(31),
				($urandom_range(3) == 0) ? any_q() : small_q(2 * Q_ONE), $urandom, $urandom);
		else if (pick < 52)
			issue(OP_LOAD_REF, $urandom_range(31), $urandom_range(31),
				any_q(), any_q(), any_q());
		else if (pick < 58)
			issue(OP_COMPUTE, $urandom_range(31), $urandom_range(31),
				$urandom, $urandom, $urandom);
		else if (pick < 96) begin
			if ($urandom_range(3) == 0)
				issue(OP_READ, $urandom_range(31), $urandom_range(31), $urandom,
					$urandom, $urandom);
			else
				issue(OP_READ, $urandom_range(nr - 1), $urandom_range(np - 1),
					$urandom, $urandom, $urandom);
		end else
			issue(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom_range(31),
				$urandom_range(31), $urandom, $urandom, $urandom);
	endtask

	initial begin
		int rw, pw, nr, np;
		cycles     = 0;
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd        = '0;
		rsp_stall  = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		quiet      = 1'b0;
		start_hold = 1'b0;
		hold_left  = 0;
		computes_run = 0;
		phases_run   = 0;
		sent         = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// singular map first so every result entry is defined before any read
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				issue(OP_LOAD_MAP, r, c, 32'h0, 32'hffff_ffff, 32'h0);
		issue(OP_COMPUTE, 0, 0, 0, 0, 0);
		issue(OP_READ, 0, 0, 0, 0, 0);
		issue(OP_READ, 31, 31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		issue(OP_LOAD_MAP, 3, 0, Q_ONE, 0, 0);
		issue(OP_LOAD_MAP, 0, 31, Q_ONE, 0, 0);
		issue(OP_LOAD_TR, 31, 31, 32'h8000_0000, 0, 0);
		issue(OP_LOAD_REF, 31, 31, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		issue(OP_SPARE_LO, 31, 31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		issue(3'd6, 0, 0, 0, 0, 0);
		issue(OP_SPARE_HI, 5, 10, 0, 0, 0);
		settle();

		// one row, points register beyond range, identity map then saturation
		prepare(0, 63, 1);
		issue(OP_COMPUTE, 0, 0, 0, 0, 0);
		issue(OP_READ, 0, 0, 0, 0, 0);
		issue(OP_READ, 0, 31, 0, 0, 0);
		issue(OP_LOAD_MAP, 0, 0, 32'h0000_0100, 0, 0);
		issue(OP_LOAD_REF, 0, 3, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		issue(OP_COMPUTE, 0, 0, 0, 0, 0);
		issue(OP_READ, 0, 3, 0, 0, 0);
		issue(OP_READ, 1, 0, 0, 0, 0);
		settle();

		// full row count, one point
		quiet = 1'b1;
		prepare(32, 1, 0);
		quiet = 1'b0;
		issue(OP_COMPUTE, 0, 0, 0, 0, 0);
		for (int r = 0; r < 32; r += 7)
			issue(OP_READ, r, 0, 0, 0, 0);
		settle();

		while (sent < 1400) begin
			rw = ($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
			pw = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
			prepare(rw, pw, ($urandom_range(5) == 0) ? 2 : 0);
			nr = span(rw, MAX_ROWS);
			np = span(pw, MAX_POINTS);
			issue(OP_COMPUTE, 0, 0, 0, 0, 0);
			if (phases_run == 3) begin
				start_hold = 1'b1;
				for (int k = 0; k < 40; k++)
					issue(OP_LOAD_REF, $urandom_range(31), $urandom_range(31),
						any_q(), any_q(), any_q());
			end
			quiet = (phases_run == 4);
			for (int k = 0; k < 90; k++)
				random_item(nr, np);
			quiet = 1'b0;
			settle();
		end

		$display("Covered %0d phases, %0d computes; beats by op: map %0d tr %0d ref %0d",
			phases_run, computes_run, op_seen[0], op_seen[1], op_seen[2]);
		$display("  read %0d, compute %0d, unused ops %0d, mismatches %0d",
			op_seen[4], op_seen[3], op_seen[5] + op_seen[6] + op_seen[7], fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
